@@ sv/frame_fft_log_power_macros.svh @@
// assertion macros for the frame log-power spectrum block
`ifndef FRAME_FFT_LOG_POWER_MACROS_SVH
`define FRAME_FFT_LOG_POWER_MACROS_SVH

// same-cycle implication, checked on every rising edge out of reset
`define FFL_ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("frame_fft_log_power: assertion failed");

// next-cycle implication
`define FFL_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("frame_fft_log_power: assertion failed");

`endif

@@ sv/ffl_pkg.sv @@
// shared constants, types and the cordic angle table of the log-power spectrum block
package ffl_pkg;

  localparam int unsigned WINDOW_LENGTH = 512;
  localparam int unsigned SAMPLE_WIDTH  = 16;
  localparam int unsigned MAX_BINS      = 64;
  localparam int unsigned COUNT_W       = 7;
  localparam int unsigned BIN_W         = 6;
  localparam int unsigned LOG_W         = 16;
  localparam int unsigned TW_W          = 18;

  localparam logic [COUNT_W-1:0] COUNT_RESET = 7'd20;
  localparam logic signed [33:0] CORDIC_X0   = 34'sd652032874;
  localparam logic signed [24:0] LN2_Q24     = 25'sd11629080;

  typedef struct packed {
    logic               bank;
    logic [COUNT_W-1:0] count;
  } job_t;

  typedef struct packed {
    logic empty;
    logic full;
  } fifo_stat_t;

  typedef struct packed {
    logic                    zero;
    logic signed [LOG_W-1:0] ln;
  } log_res_t;

  // atan(2^-i) on a 32-bit phase circle
  function automatic logic signed [32:0] atan_step(input logic [3:0] i);
    logic signed [32:0] v;
    case (i)
      4'd0:    v = 33'sd536870912;
      4'd1:    v = 33'sd316933406;
      4'd2:    v = 33'sd167458907;
      4'd3:    v = 33'sd85004756;
      4'd4:    v = 33'sd42667331;
      4'd5:    v = 33'sd21354465;
      4'd6:    v = 33'sd10680862;
      4'd7:    v = 33'sd5340245;
      4'd8:    v = 33'sd2670163;
      4'd9:    v = 33'sd1335087;
      4'd10:   v = 33'sd667544;
      4'd11:   v = 33'sd333772;
      4'd12:   v = 33'sd166886;
      4'd13:   v = 33'sd83443;
      4'd14:   v = 33'sd41722;
      4'd15:   v = 33'sd20861;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

@@ sv/ffl_ram.sv @@
// generic single-write, single-read ram with registered read data
module ffl_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 512,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ sv/ffl_front.sv @@
// sample intake: frame position, bank select, count register and job issue
module ffl_front #(
  parameter int unsigned WINDOW_LENGTH = ffl_pkg::WINDOW_LENGTH,
  parameter int unsigned SAMPLE_WIDTH  = ffl_pkg::SAMPLE_WIDTH,
  localparam int unsigned AW  = $clog2(WINDOW_LENGTH),
  localparam int unsigned FAW = $clog2(2 * WINDOW_LENGTH)
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [SAMPLE_WIDTH-1:0]      sample_i,
  input  logic                         cfg_we_i,
  input  logic [ffl_pkg::COUNT_W-1:0]  cfg_wdata_i,
  output logic                         we_o,
  output logic [FAW-1:0]               waddr_o,
  output logic [SAMPLE_WIDTH-1:0]      wdata_o,
  output logic                         push_o,
  output ffl_pkg::job_t                job_o,
  input  logic                         job_done_i
);

  localparam int unsigned HALF_BINS = WINDOW_LENGTH / 2 + 1;
  localparam int unsigned CAP = (HALF_BINS < ffl_pkg::MAX_BINS) ? HALF_BINS : ffl_pkg::MAX_BINS;
  localparam logic [ffl_pkg::COUNT_W-1:0] CAP_C = ffl_pkg::COUNT_W'(CAP);
  localparam logic [AW-1:0] POS_LAST = AW'(WINDOW_LENGTH - 1);

  logic [AW-1:0]               pos_q, pos_d;
  logic                        bank_q, bank_d;
  logic [1:0]                  jobs_q, jobs_d;
  logic [ffl_pkg::COUNT_W-1:0] cfg_q, cfg_d;
  logic [ffl_pkg::COUNT_W-1:0] eff_count;
  logic                        accept;

  assign in_stall_o = (jobs_q == 2'd2);
  assign accept     = in_valid_i && !in_stall_o;
  assign eff_count  = (cfg_q > CAP_C) ? CAP_C : cfg_q;

  assign we_o    = accept;
  assign wdata_o = sample_i;
  assign waddr_o = FAW'(pos_q) + (bank_q ? FAW'(WINDOW_LENGTH) : FAW'(0));

  assign push_o      = accept && (pos_q == POS_LAST) && (eff_count != '0);
  assign job_o.bank  = bank_q;
  assign job_o.count = eff_count;

  always_comb begin
    pos_d  = pos_q;
    bank_d = bank_q;
    cfg_d  = cfg_q;
    jobs_d = jobs_q + {1'b0, push_o} - {1'b0, job_done_i};
    if (cfg_we_i) begin
      cfg_d = cfg_wdata_i;
    end
    if (accept) begin
      if (pos_q == POS_LAST) begin
        pos_d = '0;
        if (push_o) begin
          bank_d = !bank_q;
        end
      end else begin
        pos_d = pos_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      bank_q <= 1'b0;
      jobs_q <= '0;
      cfg_q  <= ffl_pkg::COUNT_RESET;
    end else begin
      pos_q  <= pos_d;
      bank_q <= bank_d;
      jobs_q <= jobs_d;
      cfg_q  <= cfg_d;
    end
  end

endmodule

@@ sv/ffl_job_fifo.sv @@
// two-entry job queue between intake and transform
module ffl_job_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  ffl_pkg::job_t       job_i,
  input  logic                pop_i,
  output ffl_pkg::job_t       job_o,
  output ffl_pkg::fifo_stat_t stat_o
);

  ffl_pkg::job_t entry_q [2];
  logic          wr_q, rd_q;
  logic [1:0]    cnt_q;

  assign job_o        = entry_q[rd_q];
  assign stat_o.empty = (cnt_q == 2'd0);
  assign stat_o.full  = (cnt_q == 2'd2);

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= !wr_q;
      end
      if (pop_i) begin
        rd_q <= !rd_q;
      end
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

endmodule

@@ sv/ffl_log_unit.sv @@
// iterative magnitude-squared and natural log in q7.8
module ffl_log_unit #(
  parameter int unsigned ACC_W = 52
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic signed [ACC_W-1:0] re_i,
  input  logic signed [ACC_W-1:0] im_i,
  output logic                    done_o,
  output ffl_pkg::log_res_t       res_o
);

  localparam int unsigned S_W = $clog2(ACC_W);

  typedef enum logic [7:0] {
    L_IDLE  = 8'b00000001,
    L_SHIFT = 8'b00000010,
    L_SQ    = 8'b00000100,
    L_SUM   = 8'b00001000,
    L_NORM  = 8'b00010000,
    L_FRAC  = 8'b00100000,
    L_LN    = 8'b01000000,
    L_SAT   = 8'b10000000
  } log_state_e;

  log_state_e         state_q, state_d;
  logic               done_q, done_d;
  logic [ACC_W-1:0]   a_q, a_d, b_q, b_d;
  logic [S_W-1:0]     s_q, s_d;
  logic [61:0]        sqa_q, sqa_d, sqb_q, sqb_d;
  logic [62:0]        m_q, m_d;
  logic [5:0]         p_q, p_d;
  logic [15:0]        frac_q, frac_d;
  logic [3:0]         it_q, it_d;
  logic signed [50:0] prod_q, prod_d;
  ffl_pkg::log_res_t  res_q, res_d;

  logic [ACC_W-1:0]   ab;
  logic [30:0]        a31, b31, m31;
  logic [61:0]        msq;
  logic [31:0]        t;
  logic signed [9:0]  lint;
  logic signed [25:0] lval;
  logic signed [50:0] rsum;
  logic signed [18:0] q;

  assign ab   = a_q | b_q;
  assign a31  = 31'(a_q);
  assign b31  = 31'(b_q);
  assign m31  = m_q[30:0];
  assign msq  = m31 * m31;
  assign t    = msq[61:30];
  assign lint = 10'(p_q) + 10'({s_q, 1'b0}) - 10'd30;
  assign lval = {lint, frac_q};
  assign rsum = prod_q + 51'sh8000_0000;
  assign q    = rsum[50:32];

  always_comb begin
    state_d = state_q;
    done_d  = 1'b0;
    a_d     = a_q;
    b_d     = b_q;
    s_d     = s_q;
    sqa_d   = sqa_q;
    sqb_d   = sqb_q;
    m_d     = m_q;
    p_d     = p_q;
    frac_d  = frac_q;
    it_d    = it_q;
    prod_d  = prod_q;
    res_d   = res_q;
    case (state_q)
      L_IDLE: begin
        if (start_i) begin
          a_d = re_i[ACC_W-1] ? $unsigned(-re_i) : $unsigned(re_i);
          b_d = im_i[ACC_W-1] ? $unsigned(-im_i) : $unsigned(im_i);
          s_d = '0;
          if (re_i == '0 && im_i == '0) begin
            // no energy in the bin: clamp to the minimum and flag it
            res_d.zero = 1'b1;
            res_d.ln   = 16'sh8000;
            done_d     = 1'b1;
          end else begin
            state_d = L_SHIFT;
          end
        end
      end
      L_SHIFT: begin
        if ((ab >> 31) != '0) begin
          a_d = a_q >> 1;
          b_d = b_q >> 1;
          s_d = s_q + 1'b1;
        end else begin
          state_d = L_SQ;
        end
      end
      L_SQ: begin
        sqa_d   = a31 * a31;
        sqb_d   = b31 * b31;
        state_d = L_SUM;
      end
      L_SUM: begin
        m_d     = {1'b0, sqa_q} + {1'b0, sqb_q};
        p_d     = 6'd30;
        state_d = L_NORM;
      end
      L_NORM: begin
        if (m_q[62:31] != '0) begin
          m_d = m_q >> 1;
          p_d = p_q + 1'b1;
        end else if (!m_q[30]) begin
          m_d = m_q << 1;
          p_d = p_q - 1'b1;
        end else begin
          it_d    = '0;
          frac_d  = '0;
          state_d = L_FRAC;
        end
      end
      L_FRAC: begin
        m_d    = t[31] ? 63'(t[31:1]) : 63'(t[30:0]);
        frac_d = {frac_q[14:0], t[31]};
        it_d   = it_q + 1'b1;
        if (it_q == 4'd15) begin
          state_d = L_LN;
        end
      end
      L_LN: begin
        prod_d  = lval * ffl_pkg::LN2_Q24;
        state_d = L_SAT;
      end
      L_SAT: begin
        res_d.zero = 1'b0;
        if (q > 19'sd32767) begin
          res_d.ln = 16'sh7fff;
        end else if (q < -19'sd32768) begin
          res_d.ln = 16'sh8000;
        end else begin
          res_d.ln = q[15:0];
        end
        done_d  = 1'b1;
        state_d = L_IDLE;
      end
      default: state_d = L_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= L_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q    <= a_d;
    b_q    <= b_d;
    s_q    <= s_d;
    sqa_q  <= sqa_d;
    sqb_q  <= sqb_d;
    m_q    <= m_d;
    p_q    <= p_d;
    frac_q <= frac_d;
    it_q   <= it_d;
    prod_q <= prod_d;
    res_q  <= res_d;
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

@@ sv/ffl_back.sv @@
// transform engine: twiddle build, per-bin multiply-accumulate, log and result register
module ffl_back #(
  parameter int unsigned WINDOW_LENGTH = ffl_pkg::WINDOW_LENGTH,
  parameter int unsigned SAMPLE_WIDTH  = ffl_pkg::SAMPLE_WIDTH,
  localparam int unsigned AW  = $clog2(WINDOW_LENGTH),
  localparam int unsigned FAW = $clog2(2 * WINDOW_LENGTH)
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  ffl_pkg::job_t                     job_i,
  input  ffl_pkg::fifo_stat_t               stat_i,
  output logic                              pop_o,
  output logic [FAW-1:0]                    raddr_o,
  input  logic [SAMPLE_WIDTH-1:0]           rdata_i,
  output logic                              job_done_o,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [ffl_pkg::BIN_W-1:0]         bin_index_o,
  output logic signed [ffl_pkg::LOG_W-1:0]  log_power_o,
  output logic                              zero_power_o,
  output logic                              last_o
);

  localparam int unsigned TW_W  = ffl_pkg::TW_W;
  localparam int unsigned P_W   = SAMPLE_WIDTH + TW_W;
  localparam int unsigned ACC_W = SAMPLE_WIDTH + TW_W + AW;
  localparam longint unsigned PH_ONE = 64'h1_0000_0000;
  localparam longint unsigned PH_Q   = PH_ONE / WINDOW_LENGTH;
  localparam longint unsigned PH_R   = PH_ONE % WINDOW_LENGTH;
  localparam logic [31:0] PH_Q_C     = 32'(PH_Q);
  localparam logic [AW:0] PH_R_C     = (AW + 1)'(PH_R);
  localparam logic [AW:0] N_C        = (AW + 1)'(WINDOW_LENGTH);
  localparam logic [AW-1:0] LAST_C   = AW'(WINDOW_LENGTH - 1);

  typedef enum logic [6:0] {
    B_TW_SETUP = 7'b0000001,
    B_TW_ITER  = 7'b0000010,
    B_TW_STORE = 7'b0000100,
    B_IDLE     = 7'b0001000,
    B_MAC      = 7'b0010000,
    B_LOG      = 7'b0100000,
    B_OUT      = 7'b1000000
  } back_state_e;

  back_state_e state_q, state_d;

  // twiddle build
  logic [AW-1:0]      tw_m_q, tw_m_d;
  logic [31:0]        ph_q, ph_d;
  logic [AW:0]        rem_q, rem_d;
  logic signed [33:0] cx_q, cx_d, cy_q, cy_d;
  logic signed [32:0] cz_q, cz_d;
  logic               flip_q, flip_d;
  logic [3:0]         it_q, it_d;

  // accumulation
  ffl_pkg::job_t               job_q, job_d;
  logic [ffl_pkg::BIN_W-1:0]   k_q, k_d;
  logic [AW-1:0]               n_q, n_d, idx_q, idx_d;
  logic                        issue_q, issue_d, v1_q, v1_d, v2_q, v2_d;
  logic signed [P_W-1:0]       prod_re_q, prod_re_d, prod_im_q, prod_im_d;
  logic signed [ACC_W-1:0]     acc_re_q, acc_re_d, acc_im_q, acc_im_d;

  // result register
  logic                              out_valid_q, out_valid_d;
  logic [ffl_pkg::BIN_W-1:0]         bin_q, bin_d;
  logic signed [ffl_pkg::LOG_W-1:0]  ln_q, ln_d;
  logic                              zero_q, zero_d, last_q, last_d;

  logic               tw_we;
  logic [2*TW_W-1:0]  tw_wdata, tw_rdata;
  logic signed [TW_W-1:0] tw_c, tw_s;
  logic signed [33:0] dx, dy, fx, fy, rc, rs;
  logic signed [32:0] atan_v;
  logic [31:0]        phf;
  logic [AW:0]        rem_sum, idx_sum;
  logic               log_start, log_done, load, bin_last;
  ffl_pkg::log_res_t  log_res;

  assign dx      = cy_q >>> it_q;
  assign dy      = cx_q >>> it_q;
  assign atan_v  = ffl_pkg::atan_step(it_q);
  assign fx      = flip_q ? -cx_q : cx_q;
  assign fy      = flip_q ? -cy_q : cy_q;
  assign rc      = fx + 34'sd16384;
  assign rs      = fy + 34'sd16384;
  assign rem_sum = rem_q + PH_R_C;
  assign idx_sum = {1'b0, idx_q} + (AW + 1)'(k_q);
  assign tw_c    = tw_rdata[2*TW_W-1:TW_W];
  assign tw_s    = tw_rdata[TW_W-1:0];
  assign raddr_o = FAW'(n_q) + (job_q.bank ? FAW'(WINDOW_LENGTH) : FAW'(0));
  assign load     = (state_q == B_OUT) && (!out_valid_q || !out_stall_i);
  assign bin_last = ({1'b0, k_q} + 1'b1) == job_q.count;
  assign log_start = (state_q == B_MAC) && !issue_q && !v1_q && !v2_q;

  ffl_ram #(
    .WIDTH (2 * TW_W),
    .DEPTH (WINDOW_LENGTH)
  ) u_tw_ram (
    .clk_i   (clk_i),
    .we_i    (tw_we),
    .waddr_i (tw_m_q),
    .wdata_i (tw_wdata),
    .raddr_i (idx_q),
    .rdata_o (tw_rdata)
  );

  ffl_log_unit #(
    .ACC_W (ACC_W)
  ) u_log (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (log_start),
    .re_i    (acc_re_q),
    .im_i    (acc_im_q),
    .done_o  (log_done),
    .res_o   (log_res)
  );

  always_comb begin
    state_d     = state_q;
    tw_m_d      = tw_m_q;
    ph_d        = ph_q;
    rem_d       = rem_q;
    cx_d        = cx_q;
    cy_d        = cy_q;
    cz_d        = cz_q;
    flip_d      = flip_q;
    it_d        = it_q;
    job_d       = job_q;
    k_d         = k_q;
    n_d         = n_q;
    idx_d       = idx_q;
    issue_d     = issue_q;
    v1_d        = 1'b0;
    v2_d        = 1'b0;
    prod_re_d   = prod_re_q;
    prod_im_d   = prod_im_q;
    acc_re_d    = acc_re_q;
    acc_im_d    = acc_im_q;
    out_valid_d = out_valid_q && out_stall_i;
    bin_d       = bin_q;
    ln_d        = ln_q;
    zero_d      = zero_q;
    last_d      = last_q;
    tw_we       = 1'b0;
    tw_wdata    = {rc[TW_W+14:15], rs[TW_W+14:15]};
    phf         = {ph_q[31] ^ ph_q[30] ^ ph_q[31], ph_q[30:0]};
    pop_o       = 1'b0;
    job_done_o  = 1'b0;
    case (state_q)
      B_TW_SETUP: begin
        // quadrants two and three rotate by half a turn first
        flip_d  = ph_q[31] ^ ph_q[30];
        phf     = {ph_q[31] ^ flip_d, ph_q[30:0]};
        cz_d    = $signed({phf[31], phf});
        cx_d    = ffl_pkg::CORDIC_X0;
        cy_d    = '0;
        it_d    = '0;
        state_d = B_TW_ITER;
      end
      B_TW_ITER: begin
        if (!cz_q[32]) begin
          cx_d = cx_q - dx;
          cy_d = cy_q + dy;
          cz_d = cz_q - atan_v;
        end else begin
          cx_d = cx_q + dx;
          cy_d = cy_q - dy;
          cz_d = cz_q + atan_v;
        end
        it_d = it_q + 1'b1;
        if (it_q == 4'd15) begin
          state_d = B_TW_STORE;
        end
      end
      B_TW_STORE: begin
        tw_we = 1'b1;
        if (rem_sum >= N_C) begin
          rem_d = rem_sum - N_C;
          ph_d  = ph_q + PH_Q_C + 32'd1;
        end else begin
          rem_d = rem_sum;
          ph_d  = ph_q + PH_Q_C;
        end
        if (tw_m_q == LAST_C) begin
          state_d = B_IDLE;
        end else begin
          tw_m_d  = tw_m_q + 1'b1;
          state_d = B_TW_SETUP;
        end
      end
      B_IDLE: begin
        if (!stat_i.empty) begin
          pop_o    = 1'b1;
          job_d    = job_i;
          k_d      = '0;
          n_d      = '0;
          idx_d    = '0;
          issue_d  = 1'b1;
          acc_re_d = '0;
          acc_im_d = '0;
          state_d  = B_MAC;
        end
      end
      B_MAC: begin
        // issue, product and accumulate run as a three-deep pipeline
        v1_d = issue_q;
        v2_d = v1_q;
        if (issue_q) begin
          if (n_q == LAST_C) begin
            issue_d = 1'b0;
          end else begin
            n_d = n_q + 1'b1;
          end
          idx_d = (idx_sum >= N_C) ? AW'(idx_sum - N_C) : AW'(idx_sum);
        end
        if (v1_q) begin
          prod_re_d = $signed(rdata_i) * tw_c;
          prod_im_d = $signed(rdata_i) * tw_s;
        end
        if (v2_q) begin
          acc_re_d = acc_re_q + ACC_W'(prod_re_q);
          acc_im_d = acc_im_q - ACC_W'(prod_im_q);
        end
        if (log_start) begin
          state_d = B_LOG;
        end
      end
      B_LOG: begin
        if (log_done) begin
          state_d = B_OUT;
        end
      end
      B_OUT: begin
        if (load) begin
          out_valid_d = 1'b1;
          bin_d       = k_q;
          ln_d        = log_res.ln;
          zero_d      = log_res.zero;
          last_d      = bin_last;
          if (bin_last) begin
            job_done_o = 1'b1;
            state_d    = B_IDLE;
          end else begin
            k_d      = k_q + 1'b1;
            n_d      = '0;
            idx_d    = '0;
            issue_d  = 1'b1;
            acc_re_d = '0;
            acc_im_d = '0;
            state_d  = B_MAC;
          end
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_TW_SETUP;
      tw_m_q      <= '0;
      ph_q        <= '0;
      rem_q       <= '0;
      issue_q     <= 1'b0;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      tw_m_q      <= tw_m_d;
      ph_q        <= ph_d;
      rem_q       <= rem_d;
      issue_q     <= issue_d;
      v1_q        <= v1_d;
      v2_q        <= v2_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cx_q      <= cx_d;
    cy_q      <= cy_d;
    cz_q      <= cz_d;
    flip_q    <= flip_d;
    it_q      <= it_d;
    job_q     <= job_d;
    k_q       <= k_d;
    n_q       <= n_d;
    idx_q     <= idx_d;
    prod_re_q <= prod_re_d;
    prod_im_q <= prod_im_d;
    acc_re_q  <= acc_re_d;
    acc_im_q  <= acc_im_d;
    bin_q     <= bin_d;
    ln_q      <= ln_d;
    zero_q    <= zero_d;
    last_q    <= last_d;
  end

  assign out_valid_o  = out_valid_q;
  assign bin_index_o  = bin_q;
  assign log_power_o  = ln_q;
  assign zero_power_o = zero_q;
  assign last_o       = last_q;

endmodule

@@ sv/frame_fft_log_power.sv @@
// Intake takes one sample beat per cycle while fewer than two frames are queued or in work.
// Each bin is a multiply-accumulate over the frame through one twiddle ram port, followed
// by an iterative log. After reset the twiddle table is built; samples are taken meanwhile,
// results wait for the build. Position and bank clear on reset; the count resets to 20.
module frame_fft_log_power #(
  parameter int unsigned WINDOW_LENGTH = ffl_pkg::WINDOW_LENGTH,
  parameter int unsigned SAMPLE_WIDTH  = ffl_pkg::SAMPLE_WIDTH
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // sample channel
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [SAMPLE_WIDTH-1:0]           sample_i,
  // coefficient count register
  input  logic                              cfg_we_i,
  input  logic [ffl_pkg::COUNT_W-1:0]       cfg_wdata_i,
  // result channel
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [ffl_pkg::BIN_W-1:0]         bin_index_o,
  output logic signed [ffl_pkg::LOG_W-1:0]  log_power_o,
  output logic                              zero_power_o,
  output logic                              last_o
);

  `include "frame_fft_log_power_macros.svh"

  localparam int unsigned FAW = $clog2(2 * WINDOW_LENGTH);

  // frame ram: two banks so one frame fills while the other is transformed
  logic                    fr_we;
  logic [FAW-1:0]          fr_waddr, fr_raddr;
  logic [SAMPLE_WIDTH-1:0] fr_wdata, fr_rdata;

  // job hand-off between intake and transform
  logic                fifo_push, fifo_pop, job_done;
  ffl_pkg::job_t       push_job, head_job;
  ffl_pkg::fifo_stat_t fifo_stat;

  ffl_front #(
    .WINDOW_LENGTH (WINDOW_LENGTH),
    .SAMPLE_WIDTH  (SAMPLE_WIDTH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .sample_i    (sample_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .we_o        (fr_we),
    .waddr_o     (fr_waddr),
    .wdata_o     (fr_wdata),
    .push_o      (fifo_push),
    .job_o       (push_job),
    .job_done_i  (job_done)
  );

  ffl_ram #(
    .WIDTH (SAMPLE_WIDTH),
    .DEPTH (2 * WINDOW_LENGTH)
  ) u_frame_ram (
    .clk_i   (clk_i),
    .we_i    (fr_we),
    .waddr_i (fr_waddr),
    .wdata_i (fr_wdata),
    .raddr_i (fr_raddr),
    .rdata_o (fr_rdata)
  );

  ffl_job_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (fifo_push),
    .job_i  (push_job),
    .pop_i  (fifo_pop),
    .job_o  (head_job),
    .stat_o (fifo_stat)
  );

  // transform side: direct dft per bin, exact sums, then the log unit
  ffl_back #(
    .WINDOW_LENGTH (WINDOW_LENGTH),
    .SAMPLE_WIDTH  (SAMPLE_WIDTH)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .job_i        (head_job),
    .stat_i       (fifo_stat),
    .pop_o        (fifo_pop),
    .raddr_o      (fr_raddr),
    .rdata_i      (fr_rdata),
    .job_done_o   (job_done),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .bin_index_o  (bin_index_o),
    .log_power_o  (log_power_o),
    .zero_power_o (zero_power_o),
    .last_o       (last_o)
  );

  // bank credits keep the queue from overflowing
  `FFL_ASSERT_IMPL(a_push_has_room, fifo_push, !fifo_stat.full)
  // transform only takes a job that is there
  `FFL_ASSERT_IMPL(a_pop_has_job, fifo_pop, !fifo_stat.empty)
  // a zero-power bin always carries the clamped minimum
  `FFL_ASSERT_IMPL(a_zero_is_min, out_valid_o && zero_power_o, log_power_o == 16'h8000)
  // a finished job always comes with its last result beat loaded
  `FFL_ASSERT_NEXT(a_done_loads_last, job_done, out_valid_o && last_o)

endmodule

@@ tb/tb_top.sv @@
// testbench for frame_fft_log_power: frames of samples in, checked log-power bins out
module tb_top;

  localparam int unsigned FRAME = ffl_pkg::WINDOW_LENGTH;

  // one expected spectrum bin
  typedef struct {
    bit [5:0]         bin;
    bit signed [15:0] lp;
    bit               zero;
    bit               last;
  } bin_beat_t;

  // keeps its own frame, twiddles and coefficient count, predicts the bins of each frame
  class spectrum_board;
    bin_beat_t   pending[$];
    int          errors;
    longint      cos_q15[FRAME];
    longint      sin_q15[FRAME];
    longint      frame_buf[FRAME];
    int          fill;
    int unsigned coef_count;
    longint      atan_tab[16];

    function new();
      longint c, s;
      atan_tab = '{536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
                   10680862, 5340245, 2670163, 1335087, 667544, 333772, 166886,
                   83443, 41722, 20861};
      for (int m = 0; m < FRAME; m++) begin
        rotate(32'(64'(m) * 64'h1_0000_0000 / FRAME), c, s);
        cos_q15[m] = c;
        sin_q15[m] = s;
      end
      coef_count = 20;
    endfunction

    // 16-step cordic, q2.30 rounded to q1.15
    function void rotate(bit [31:0] phase, output longint co, output longint si);
      longint x, y, z, dx, dy;
      bit flip;
      flip = (phase[31:30] == 2'd1) || (phase[31:30] == 2'd2);
      if (flip) phase = phase - 32'h8000_0000;
      z = phase[31] ? longint'(phase) - 64'sd4294967296 : longint'(phase);
      x = 652032874;
      y = 0;
      for (int i = 0; i < 16; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (z >= 0) begin
          x -= dx; y += dy; z -= atan_tab[i];
        end else begin
          x += dx; y -= dy; z += atan_tab[i];
        end
      end
      if (flip) begin
        x = -x; y = -y;
      end
      co = (x + 16384) >>> 15;
      si = (y + 16384) >>> 15;
    endfunction

    // log2 in q.16: msb position plus 16 fraction bits by repeated squaring
    function longint log2_fx(longint unsigned v);
      int p;
      longint unsigned m;
      longint r;
      p = 0;
      while (p < 63 && (v >> (p + 1)) != 0) p++;
      m = (p < 30) ? (v << (30 - p)) : (v >> (p - 30));
      r = longint'(p) * 65536;
      for (int i = 0; i < 16; i++) begin
        m = (m * m) >> 30;
        if (m >= 64'h8000_0000) begin
          m >>= 1;
          r += longint'(1) << (15 - i);
        end
      end
      return r;
    endfunction

    function void fail(string msg);
      errors++;
      if (errors <= 10) $display("%s", msg);
    endfunction

    // accepted sample beat; a completed frame queues its bins
    function void note_sample(logic signed [15:0] x);
      int unsigned cnt, idx, sh;
      longint re, im, l2, ln;
      longint unsigned a, b;
      bin_beat_t e;
      frame_buf[fill] = x;
      fill++;
      if (fill < FRAME) return;
      fill = 0;
      cnt = coef_count;
      if (cnt > 64) cnt = 64;
      if (cnt > FRAME / 2 + 1) cnt = FRAME / 2 + 1;
      for (int unsigned k = 0; k < cnt; k++) begin
        re = 0;
        im = 0;
        idx = 0;
        for (int n = 0; n < FRAME; n++) begin
          re += frame_buf[n] * cos_q15[idx];
          im -= frame_buf[n] * sin_q15[idx];
          idx = (idx + k) % FRAME;
        end
        e.bin  = k[5:0];
        e.last = (k + 1 == cnt);
        a = re < 0 ? -re : re;
        b = im < 0 ? -im : im;
        if ((a | b) == 0) begin
          e.lp   = -16'sd32768;
          e.zero = 1'b1;
        end else begin
          // scale so both parts fit 31 bits before squaring
          sh = 0;
          while (((a | b) >> sh) >= 64'h8000_0000) sh++;
          a >>= sh;
          b >>= sh;
          l2 = log2_fx(a * a + b * b) + (longint'(2 * sh) - 30) * 65536;
          ln = (l2 * 11629080 + 64'sd2147483648) >>> 32;
          if (ln > 32767) ln = 32767;
          if (ln < -32768) ln = -32768;
          e.lp   = ln[15:0];
          e.zero = 1'b0;
        end
        pending.push_back(e);
      end
    endfunction

    // accepted result beat against the oldest expected bin
    function void check_bin(bit [5:0] bin, bit signed [15:0] lp, bit zero, bit last);
      bin_beat_t e;
      if (pending.size() == 0) begin
        fail($sformatf("unexpected result beat: bin %0d log %0d zero %0d last %0d",
                       bin, lp, zero, last));
        return;
      end
      e = pending.pop_front();
      if (bin !== e.bin || lp !== e.lp || zero !== e.zero || last !== e.last)
        fail($sformatf("bin mismatch: exp bin %0d log %0d zero %0d last %0d, got %0d %0d %0d %0d",
                       e.bin, e.lp, e.zero, e.last, bin, lp, zero, last));
    endfunction
  endclass

  logic                              clk_i;
  logic                              rst_ni;
  logic                              in_valid_i;
  logic                              in_stall_o;
  logic [ffl_pkg::SAMPLE_WIDTH-1:0]  sample_i;
  logic                              cfg_we_i;
  logic [ffl_pkg::COUNT_W-1:0]       cfg_wdata_i;
  logic                              out_valid_o;
  logic                              out_stall_i;
  logic [ffl_pkg::BIN_W-1:0]         bin_index_o;
  logic signed [ffl_pkg::LOG_W-1:0]  log_power_o;
  logic                              zero_power_o;
  logic                              last_o;

  spectrum_board board;
  bit  tx_fast;       // sender offers back to back
  bit  rx_fast;       // receiver never idles between beats
  int  rx_wait;       // idle cycles before the next result beat
  int  rx_hold;       // long hold-off, counted down by the receiver

  frame_fft_log_power dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .sample_i     (sample_i),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .bin_index_o  (bin_index_o),
    .log_power_o  (log_power_o),
    .zero_power_o (zero_power_o),
    .last_o       (last_o)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // result side: stalls drawn per beat, plus the long hold-off
  always @(negedge clk_i) begin
    if (rx_hold > 0) begin
      out_stall_i <= 1'b1;
      rx_hold--;
    end else if (rx_wait > 0) begin
      out_stall_i <= 1'b1;
      rx_wait--;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // result monitor, sampled on the rising edge
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      board.check_bin(bin_index_o, log_power_o, zero_power_o, last_o);
      rx_wait = rx_fast ? 0 : $urandom_range(0, 13);
    end
  end

  // one sample beat; entered and left at a falling edge
  task automatic send_sample(logic signed [15:0] x);
    int gap;
    gap = tx_fast ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    sample_i   <= x;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    board.note_sample(x);
    @(negedge clk_i);
  endtask

  // mix of full-scale, small and rail values
  function automatic logic signed [15:0] draw_sample();
    case ($urandom_range(0, 5))
      0:       return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      1, 2:    return 16'($signed($urandom_range(0, 63)) - 32);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic write_count(logic [ffl_pkg::COUNT_W-1:0] v);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    board.coef_count = v;
    @(negedge clk_i);
  endtask

  // wait until every bin is back, then let a count-zero frame finish too
  task automatic drain();
    in_valid_i <= 1'b0;
    while (board.pending.size() != 0) @(negedge clk_i);
    repeat (1200) @(negedge clk_i);
  endtask

  task automatic random_frames(int frames);
    repeat (frames * FRAME) send_sample(draw_sample());
  endtask

  initial begin
    logic signed [15:0] edge_vals[8];
    board       = new();
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    sample_i    = '0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = '0;
    out_stall_i = 1'b0;
    tx_fast     = 1'b0;
    rx_fast     = 1'b0;
    rx_wait     = 0;
    rx_hold     = 0;
    edge_vals   = '{16'sh7fff, 16'sh8000, 16'sh0000, 16'shffff, 16'sh0001,
                    16'sh5555, 16'shaaaa, 16'sh8001};
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // default count: rails and patterns first, then random fill of the frame
    for (int i = 0; i < 24; i++) send_sample(edge_vals[i % 8]);
    repeat (FRAME - 24) send_sample(draw_sample());
    drain();

    // single bin of an all-zero frame gives the zero-power flag
    write_count(7'd1);
    repeat (FRAME) send_sample(16'sh0000);
    drain();

    // full 64 bins of a rail frame, receiver without idling
    write_count(7'd64);
    rx_fast = 1'b1;
    repeat (FRAME) send_sample(16'sh8000);
    drain();
    rx_fast = 1'b0;

    // count above the bin limit clamps to 64
    write_count(7'd127);
    random_frames(1);
    drain();

    // count zero: a frame with no results
    write_count(7'd0);
    random_frames(1);
    drain();

    // back-to-back frames against a long receiver hold-off to fill the block
    write_count(7'd45);
    tx_fast = 1'b1;
    rx_hold = 40000;
    random_frames(3);
    tx_fast = 1'b0;
    random_frames(1);
    in_valid_i <= 1'b0;

    while (board.pending.size() != 0) @(negedge clk_i);
    repeat (1000) @(negedge clk_i);
    if (board.errors == 0 && board.pending.size() == 0)
      $display("tb_top: done, clean");
    else
      $display("tb_top: done, errors");
    $finish;
  end

  // run limit
  initial begin
    #30000000;
    $display("tb_top: done, errors");
    $finish;
  end

endmodule
